[design/ps2_mouse_packet_tracker_assert.svh]
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_assert.svh
// Assertion macros used by the tracker's checker.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH

// Clocked property, disabled while reset is low.
`define PMT_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("pmt assertion failed");

// Signal keeps its value after any cycle in which a transaction is stalled.
`define PMT_ASSERT_HOLD(name, clk, rst_n, vld, rdy, sig) \
	name: assert property (@(posedge clk) disable iff (!rst_n) \
		(vld && !rdy) |=> $stable(sig)) \
		else $error("pmt stalled signal changed");

`endif

[design/pmt_pkg.sv]
// ----------------------------------------------------------------------------
// pmt_pkg
// Types and constants of the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmt_pkg;

	localparam int POS_BITS    = 12;
	localparam int CFG_BITS    = 12;
	localparam int CURSOR_BITS = 12;
	localparam int BTN_BITS    = 3;
	localparam int BYTE_BITS   = 8;
	localparam int DELTA_BITS  = BYTE_BITS + 1;
	localparam int AXW = ((POS_BITS > CFG_BITS) ? POS_BITS : CFG_BITS) + 2;

	localparam logic [BYTE_BITS-1:0] OVF_X = 8'h80;
	localparam logic [BYTE_BITS-1:0] OVF_Y = 8'h40;
	localparam int SIGN_X_BIT  = 4;
	localparam int SIGN_Y_BIT  = 5;
	localparam int EDGE_LO     = 2;
	localparam int EDGE_MARGIN = 18;

	localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 12'd1024;
	localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 12'd768;

	localparam int ADDR_BITS = 3;
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		PH_HEAD = 2'd0,
		PH_DX   = 2'd1,
		PH_DY   = 2'd2
	} phase_t;

	typedef struct packed {
		logic                   status;
		logic [CURSOR_BITS-1:0] cursor_x;
		logic [CURSOR_BITS-1:0] cursor_y;
		logic [BTN_BITS-1:0]    button_bits;
		logic [BTN_BITS-1:0]    prior_buttons;
	} result_t;

	localparam logic signed [AXW-1:0] LO_S     = AXW'(EDGE_LO);
	localparam logic signed [AXW-1:0] MARGIN_S = AXW'(EDGE_MARGIN);
	localparam logic signed [AXW-1:0] MAX_S    = AXW'((1 << POS_BITS) - 1);

	// Position plus delta, clamped to [2, max(2, size-18)].
	function automatic logic [POS_BITS-1:0] clamp_axis(
		input logic signed [AXW-1:0] v,
		input logic [CFG_BITS-1:0] size
	);
		logic signed [AXW-1:0] hi;
		logic signed [AXW-1:0] r;
		hi = $signed({{(AXW-CFG_BITS){1'b0}}, size}) - MARGIN_S;
		if (hi < LO_S) hi = LO_S;
		if (hi > MAX_S) hi = MAX_S;
		r = v;
		if (r < LO_S) r = LO_S;
		if (r > hi) r = hi;
		return r[POS_BITS-1:0];
	endfunction

endpackage

[design/ps2_mouse_packet_tracker.sv]
// Result: registered on acceptance of its third byte, into the output or skid register.
// Throughput: one byte per cycle; a two-entry output buffer (output register plus
// skid register) takes new bytes while results wait, in_ready drops only when both hold.
// Reset: phase at head byte, cursor at 0,0, buttons clear, screen 1024 x 768.
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// Assembles three-byte PS/2 mouse packets and tracks a clamped cursor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pmt_pkg::ADDR_BITS-1:0]        paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [pmt_pkg::BYTE_BITS-1:0]        data_byte,
	input  logic                                 ignore_byte,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 status,
	output logic [pmt_pkg::CURSOR_BITS-1:0]      cursor_x,
	output logic [pmt_pkg::CURSOR_BITS-1:0]      cursor_y,
	output logic [pmt_pkg::BTN_BITS-1:0]         button_bits,
	output logic [pmt_pkg::BTN_BITS-1:0]         prior_buttons
);

	localparam int PB  = pmt_pkg::POS_BITS;
	localparam int CB  = pmt_pkg::CFG_BITS;
	localparam int CW  = pmt_pkg::CURSOR_BITS;
	localparam int BB  = pmt_pkg::BTN_BITS;
	localparam int DW  = pmt_pkg::DELTA_BITS;
	localparam int AXW = pmt_pkg::AXW;

	logic [CB-1:0] width_q, height_q;

	pmt_pkg::phase_t phase_q, phase_next;
	logic [pmt_pkg::BYTE_BITS-1:0] head_q, dx_q;
	logic [PB-1:0] pos_x_q, pos_y_q;
	logic [BB-1:0] btn_now_q, btn_before_q;

	pmt_pkg::result_t out_q, skid_q, res;
	logic out_valid_q, skid_valid_q;

	logic act, fire, drop, pop;
	logic signed [DW-1:0] dx9, dy9;
	logic signed [AXW-1:0] sum_x, sum_y;
	logic [PB-1:0] new_x, new_y;

	// ---------------- configuration ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= pmt_pkg::WIDTH_RESET;
			height_q <= pmt_pkg::HEIGHT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				pmt_pkg::REG_SCREEN_WIDTH:  width_q  <= pwdata[CB-1:0];
				pmt_pkg::REG_SCREEN_HEIGHT: height_q <= pwdata[CB-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			pmt_pkg::REG_SCREEN_WIDTH:  prdata = {{(32-CB){1'b0}}, width_q};
			pmt_pkg::REG_SCREEN_HEIGHT: prdata = {{(32-CB){1'b0}}, height_q};
			default:                    prdata = '0;
		endcase
	end

	// ---------------- packet assembly ----------------
	assign in_ready = !skid_valid_q;
	assign act      = in_valid && in_ready && !ignore_byte;
	assign fire     = act && (phase_q == pmt_pkg::PH_DY);
	assign drop     = (head_q & (pmt_pkg::OVF_X | pmt_pkg::OVF_Y)) != '0;

	always_comb begin
		unique case (phase_q)
			pmt_pkg::PH_HEAD: phase_next = pmt_pkg::PH_DX;
			pmt_pkg::PH_DX:   phase_next = pmt_pkg::PH_DY;
			pmt_pkg::PH_DY:   phase_next = pmt_pkg::PH_HEAD;
			default:          phase_next = pmt_pkg::PH_DX;
		endcase
	end

	always_comb begin
		dx9   = $signed({head_q[pmt_pkg::SIGN_X_BIT], dx_q});
		dy9   = $signed({head_q[pmt_pkg::SIGN_Y_BIT], data_byte});
		sum_x = $signed({{(AXW-PB){1'b0}}, pos_x_q}) + $signed({{(AXW-DW){dx9[DW-1]}}, dx9});
		sum_y = $signed({{(AXW-PB){1'b0}}, pos_y_q}) - $signed({{(AXW-DW){dy9[DW-1]}}, dy9});
		new_x = pmt_pkg::clamp_axis(sum_x, width_q);
		new_y = pmt_pkg::clamp_axis(sum_y, height_q);

		res.status        = drop;
		res.cursor_x      = drop ? CW'(pos_x_q) : CW'(new_x);
		res.cursor_y      = drop ? CW'(pos_y_q) : CW'(new_y);
		res.button_bits   = head_q[BB-1:0];
		res.prior_buttons = btn_before_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= pmt_pkg::PH_HEAD;
			head_q       <= '0;
			dx_q         <= '0;
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			btn_now_q    <= '0;
			btn_before_q <= '0;
		end else if (act) begin
			phase_q <= phase_next;
			unique case (phase_q)
				pmt_pkg::PH_DX: begin
					dx_q <= data_byte;
				end
				pmt_pkg::PH_DY: begin
					if (!drop) begin
						pos_x_q   <= new_x;
						pos_y_q   <= new_y;
						btn_now_q <= head_q[BB-1:0];
					end
				end
				default: begin
					btn_before_q <= btn_now_q;
					head_q       <= data_byte;
					btn_now_q    <= data_byte[BB-1:0];
				end
			endcase
		end
	end

	// ---------------- output buffer ----------------
	assign pop = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (fire) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) out_q <= skid_q;
		end else if (fire) begin
			if (out_valid_q && !pop) skid_q <= res;
			else                     out_q  <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign cursor_x      = out_q.cursor_x;
	assign cursor_y      = out_q.cursor_y;
	assign button_bits   = out_q.button_bits;
	assign prior_buttons = out_q.prior_buttons;

endmodule

[design/pmt_checker.sv]
// ----------------------------------------------------------------------------
// pmt_checker
// Port-level checks of the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ps2_mouse_packet_tracker_assert.svh"

module pmt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            status,
	input logic [pmt_pkg::CURSOR_BITS-1:0] cursor_x,
	input logic [pmt_pkg::CURSOR_BITS-1:0] cursor_y
);

	localparam int CW = pmt_pkg::CURSOR_BITS;
	localparam logic [CW-1:0] LO = CW'(pmt_pkg::EDGE_LO);

	`PMT_ASSERT(a_out_hold, clk, arst_n, (out_valid && !out_ready |=> out_valid))
	`PMT_ASSERT_HOLD(a_out_stable, clk, arst_n, out_valid, out_ready, ({status, cursor_x, cursor_y}))
	`PMT_ASSERT(a_applied_in_bounds, clk, arst_n, (out_valid && !status |-> (cursor_x >= LO) && (cursor_y >= LO)))
	`PMT_ASSERT(a_result_from_input, clk, arst_n, (out_valid && !$past(out_valid) |-> $past(in_valid && in_ready)))

endmodule

bind ps2_mouse_packet_tracker pmt_checker u_pmt_checker (.*);
